// ----- rtl/core/dnsw_pkg.sv -----
package dnsw_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LABEL_LEN,
    PH_LABEL_BODY,
    PH_PTR_LOW,
    PH_FIXED,
    PH_RDATA,
    PH_DONE
  } phase_t;

  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_QUESTION = 2'd1;
  localparam logic [1:0] KIND_RECORD   = 2'd2;
  localparam logic [1:0] KIND_END      = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EARLY = 2'd1;
  localparam logic [1:0] STAT_EXTRA = 2'd2;

  localparam logic [1:0] SEC_QUESTION = 2'd0;

  localparam logic [7:0]  PTR_MARK       = 8'hC0;
  localparam logic [7:0]  LEN_MASK       = 8'h3F;
  localparam logic [15:0] HEADER_BYTES   = 16'd12;
  localparam logic [15:0] Q_FIXED_BYTES  = 16'd4;
  localparam logic [15:0] RR_FIXED_BYTES = 16'd10;
  localparam logic [15:0] TYPE_DONE_CNT  = 16'd1;
  localparam logic [15:0] CLASS_DONE_CNT = 16'd3;
  localparam logic [15:0] TTL_DONE_CNT   = 16'd7;
  localparam logic [15:0] RDLEN_DONE_CNT = 16'd9;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [1:0]  section;
    logic [15:0] id_or_type;
    logic [15:0] flags_or_class;
    logic [31:0] ttl_or_counts;
    logic [15:0] rdlen_or_count;
    logic [15:0] name_start_or_count;
    logic [13:0] name_pointer;
    logic [15:0] rdata_start;
    logic [1:0]  end_status;
  } result_t;

  typedef struct packed {
    logic       found;
    logic [1:0] sec;
  } sec_pick_t;

endpackage

// ----- rtl/core/dnsw_in_if.sv -----
interface dnsw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/dnsw_out_if.sv -----
interface dnsw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [1:0]  section;
  logic [15:0] id_or_type;
  logic [15:0] flags_or_class;
  logic [31:0] ttl_or_counts;
  logic [15:0] rdlen_or_count;
  logic [15:0] name_start_or_count;
  logic [13:0] name_pointer;
  logic [15:0] rdata_start;
  logic [1:0]  end_status;

  modport source (
    output valid, output item_kind, output section, output id_or_type,
    output flags_or_class, output ttl_or_counts, output rdlen_or_count,
    output name_start_or_count, output name_pointer, output rdata_start,
    output end_status, input ready
  );
  modport sink (
    input valid, input item_kind, input section, input id_or_type,
    input flags_or_class, input ttl_or_counts, input rdlen_or_count,
    input name_start_or_count, input name_pointer, input rdata_start,
    input end_status, output ready
  );
endinterface

// ----- rtl/core/dns_message_section_walker.sv -----
// A result is written into the output queue when its byte is accepted and is offered on out_if from the queue head.
// Throughput: one byte per cycle while in_if.ready is high; a byte yields zero, one or two results, queued
// in a 3-entry output queue, and in_if.ready is low while it holds two or more.
// The final byte of a message emits an end transaction and restarts at offset 0.
// Reset: synchronous, active low; clears the parse state and empties the queue.
module dns_message_section_walker (
  input logic          clk,
  input logic          rst_n,
  dnsw_in_if.sink      in_if,
  dnsw_out_if.source   out_if
);

  localparam int QDEPTH = 3;

  // parse state
  logic [15:0]          off_r, off_nxt;
  dnsw_pkg::phase_t     phase_r, phase_nxt;
  logic [31:0]          fs_r, fs_nxt;
  logic [15:0]          pc_r, pc_nxt;
  logic [3:0][15:0]     left_r, left_nxt;
  logic [1:0]           sec_r, sec_nxt;
  logic [1:0][15:0]     hdr_r, hdr_nxt;
  logic [15:0]          type_r, type_nxt;
  logic [15:0]          class_r, class_nxt;
  logic [31:0]          ttl_r, ttl_nxt;
  logic [15:0]          nstart_r, nstart_nxt;
  logic [13:0]          ptr_r, ptr_nxt;
  logic [15:0]          rdlen_r, rdlen_nxt;
  logic                 ended_r, ended_nxt;

  // output queue
  dnsw_pkg::result_t    q_r [QDEPTH];
  dnsw_pkg::result_t    q_nxt [QDEPTH];
  logic [1:0]           cnt_r, cnt_nxt;

  logic                 acc, pop;
  logic [7:0]           b;
  logic                 last;
  logic [15:0]          nxt_off;
  logic [15:0]          word;
  logic [31:0]          fs_shift;

  logic                 hdr_emit, q_emit, rr_emit, rec_emit;
  dnsw_pkg::result_t    rec_item, end_item;
  dnsw_pkg::sec_pick_t  cur_pick;

  function automatic dnsw_pkg::sec_pick_t pick_sec(input logic [1:0] cur,
                                                   input logic [3:0][15:0] left);
    dnsw_pkg::sec_pick_t p;
    p = '0;
    for (int s = 3; s >= 0; s--) begin
      if ((2'(s) >= cur) && (left[s] != 16'd0)) begin
        p.found = 1'b1;
        p.sec   = 2'(s);
      end
    end
    return p;
  endfunction

  assign acc      = in_if.valid && in_if.ready;
  assign pop      = (cnt_r != 2'd0) && out_if.ready;
  assign b        = in_if.data_byte;
  assign last     = in_if.last_byte;
  assign nxt_off  = off_r + 16'd1;
  assign word     = {fs_r[7:0], b};
  assign fs_shift = {fs_r[23:0], b};
  assign cur_pick = pick_sec(sec_r, left_r);

  assign in_if.ready = (cnt_r <= 2'd1);

  // next state
  always_comb begin
    logic                do_next;
    logic [2:0]          w;
    dnsw_pkg::sec_pick_t pk;
    do_next    = 1'b0;
    w          = pc_r[3:1];
    pk         = '0;
    off_nxt    = nxt_off;
    phase_nxt  = phase_r;
    fs_nxt     = fs_r;
    pc_nxt     = pc_r;
    left_nxt   = left_r;
    sec_nxt    = sec_r;
    hdr_nxt    = hdr_r;
    type_nxt   = type_r;
    class_nxt  = class_r;
    ttl_nxt    = ttl_r;
    nstart_nxt = nstart_r;
    ptr_nxt    = ptr_r;
    rdlen_nxt  = rdlen_r;
    ended_nxt  = ended_r;

    unique case (phase_r)
      dnsw_pkg::PH_HEADER: begin
        fs_nxt = fs_shift;
        if (pc_r[0]) begin
          if (w < 3'd2) begin
            hdr_nxt[w[0]] = word;
          end else if (w < 3'd6) begin
            left_nxt[2'(w - 3'd2)] = word;
          end
        end
        pc_nxt = pc_r + 16'd1;
        if (pc_nxt >= dnsw_pkg::HEADER_BYTES) begin
          sec_nxt = dnsw_pkg::SEC_QUESTION;
          do_next = 1'b1;
        end
      end
      dnsw_pkg::PH_LABEL_LEN: begin
        if ((b & dnsw_pkg::PTR_MARK) == dnsw_pkg::PTR_MARK) begin
          ptr_nxt   = {b[5:0], 8'd0};
          phase_nxt = dnsw_pkg::PH_PTR_LOW;
        end else if ((b & dnsw_pkg::LEN_MASK) == 8'd0) begin
          phase_nxt = dnsw_pkg::PH_FIXED;
          pc_nxt    = '0;
          fs_nxt    = '0;
        end else begin
          pc_nxt    = {10'd0, b[5:0]};
          phase_nxt = dnsw_pkg::PH_LABEL_BODY;
        end
      end
      dnsw_pkg::PH_LABEL_BODY: begin
        pc_nxt = pc_r - 16'd1;
        if (pc_nxt == 16'd0) begin
          phase_nxt = dnsw_pkg::PH_LABEL_LEN;
        end
      end
      dnsw_pkg::PH_PTR_LOW: begin
        ptr_nxt   = ptr_r | {6'd0, b};
        phase_nxt = dnsw_pkg::PH_FIXED;
        pc_nxt    = '0;
        fs_nxt    = '0;
      end
      dnsw_pkg::PH_FIXED: begin
        fs_nxt = fs_shift;
        if (pc_r == dnsw_pkg::TYPE_DONE_CNT)  type_nxt  = word;
        if (pc_r == dnsw_pkg::CLASS_DONE_CNT) class_nxt = word;
        if (pc_r == dnsw_pkg::TTL_DONE_CNT)   ttl_nxt   = fs_shift;
        if (pc_r == dnsw_pkg::RDLEN_DONE_CNT) rdlen_nxt = word;
        pc_nxt = pc_r + 16'd1;
        if (sec_r == dnsw_pkg::SEC_QUESTION) begin
          if (pc_nxt >= dnsw_pkg::Q_FIXED_BYTES) do_next = 1'b1;
        end else if (pc_nxt >= dnsw_pkg::RR_FIXED_BYTES) begin
          if (rdlen_nxt == 16'd0) begin
            do_next = 1'b1;
          end else begin
            pc_nxt    = rdlen_nxt;
            phase_nxt = dnsw_pkg::PH_RDATA;
          end
        end
      end
      dnsw_pkg::PH_RDATA: begin
        pc_nxt = pc_r - 16'd1;
        if (pc_nxt == 16'd0) do_next = 1'b1;
      end
      default: begin
        ended_nxt = 1'b1;
      end
    endcase

    if (do_next) begin
      pk = pick_sec(sec_nxt, left_nxt);
      if (pk.found) begin
        left_nxt[pk.sec] = left_nxt[pk.sec] - 16'd1;
        sec_nxt          = pk.sec;
        phase_nxt        = dnsw_pkg::PH_LABEL_LEN;
        nstart_nxt       = nxt_off;
        ptr_nxt          = '0;
        pc_nxt           = '0;
        fs_nxt           = '0;
      end else begin
        phase_nxt = dnsw_pkg::PH_DONE;
      end
    end

    if (last) begin
      off_nxt    = '0;
      phase_nxt  = dnsw_pkg::PH_HEADER;
      fs_nxt     = '0;
      pc_nxt     = '0;
      left_nxt   = '0;
      sec_nxt    = '0;
      hdr_nxt    = '0;
      type_nxt   = '0;
      class_nxt  = '0;
      ttl_nxt    = '0;
      nstart_nxt = '0;
      ptr_nxt    = '0;
      rdlen_nxt  = '0;
      ended_nxt  = 1'b0;
    end
  end

  // outputs: result items of the accepted byte
  always_comb begin
    logic ended_now;
    logic done_now;
    ended_now = (phase_r == dnsw_pkg::PH_DONE) || ended_r;
    done_now  = 1'b0;
    hdr_emit  = (phase_r == dnsw_pkg::PH_HEADER) &&
                ((pc_r + 16'd1) >= dnsw_pkg::HEADER_BYTES);
    q_emit    = (phase_r == dnsw_pkg::PH_FIXED) && (sec_r == dnsw_pkg::SEC_QUESTION) &&
                ((pc_r + 16'd1) >= dnsw_pkg::Q_FIXED_BYTES);
    rr_emit   = (phase_r == dnsw_pkg::PH_FIXED) && (sec_r != dnsw_pkg::SEC_QUESTION) &&
                ((pc_r + 16'd1) >= dnsw_pkg::RR_FIXED_BYTES);
    rec_emit  = hdr_emit || q_emit || rr_emit;

    rec_item = '0;
    if (hdr_emit) begin
      rec_item.item_kind           = dnsw_pkg::KIND_HEADER;
      rec_item.id_or_type          = hdr_r[0];
      rec_item.flags_or_class      = hdr_r[1];
      rec_item.ttl_or_counts       = {left_r[0], left_r[1]};
      rec_item.rdlen_or_count      = left_r[2];
      rec_item.name_start_or_count = word;
    end else if (q_emit) begin
      rec_item.item_kind           = dnsw_pkg::KIND_QUESTION;
      rec_item.id_or_type          = type_r;
      rec_item.flags_or_class      = word;
      rec_item.name_start_or_count = nstart_r;
      rec_item.name_pointer        = ptr_r;
    end else begin
      rec_item.item_kind           = dnsw_pkg::KIND_RECORD;
      rec_item.section             = sec_r;
      rec_item.id_or_type          = type_r;
      rec_item.flags_or_class      = class_r;
      rec_item.ttl_or_counts       = ttl_r;
      rec_item.rdlen_or_count      = word;
      rec_item.name_start_or_count = nstart_r;
      rec_item.name_pointer        = ptr_r;
      rec_item.rdata_start         = nxt_off;
    end

    // phase before the final-byte restart decides the status
    if (phase_r == dnsw_pkg::PH_DONE) begin
      done_now = 1'b1;
    end else if (rec_emit && !hdr_emit) begin
      done_now = !(q_emit || (word == 16'd0)) ? 1'b0 : !cur_pick.found;
    end else if (hdr_emit) begin
      done_now = (left_r[0] == 16'd0) && (left_r[1] == 16'd0) &&
                 (left_r[2] == 16'd0) && (word == 16'd0);
    end else if (phase_r == dnsw_pkg::PH_RDATA) begin
      done_now = (pc_r == 16'd1) && !cur_pick.found;
    end

    end_item           = '0;
    end_item.item_kind = dnsw_pkg::KIND_END;
    if (ended_now) begin
      end_item.end_status = dnsw_pkg::STAT_EXTRA;
    end else if (done_now) begin
      end_item.end_status = dnsw_pkg::STAT_OK;
    end else begin
      end_item.end_status = dnsw_pkg::STAT_EARLY;
    end
  end

  // output queue, entry 0 is the head
  always_comb begin
    logic [1:0] base;
    logic [1:0] npush;
    base  = cnt_r - {1'b0, pop};
    npush = '0;
    if (acc) npush = {1'b0, rec_emit} + {1'b0, last};
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if ((npush != 2'd0) && (2'(i) == base)) begin
        q_nxt[i] = rec_emit ? rec_item : end_item;
      end else if ((npush == 2'd2) && (2'(i) == base + 2'd1)) begin
        q_nxt[i] = end_item;
      end
    end
    cnt_nxt = base + npush;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r    <= '0;
      phase_r  <= dnsw_pkg::PH_HEADER;
      fs_r     <= '0;
      pc_r     <= '0;
      left_r   <= '0;
      sec_r    <= '0;
      hdr_r    <= '0;
      type_r   <= '0;
      class_r  <= '0;
      ttl_r    <= '0;
      nstart_r <= '0;
      ptr_r    <= '0;
      rdlen_r  <= '0;
      ended_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        off_r    <= off_nxt;
        phase_r  <= phase_nxt;
        fs_r     <= fs_nxt;
        pc_r     <= pc_nxt;
        left_r   <= left_nxt;
        sec_r    <= sec_nxt;
        hdr_r    <= hdr_nxt;
        type_r   <= type_nxt;
        class_r  <= class_nxt;
        ttl_r    <= ttl_nxt;
        nstart_r <= nstart_nxt;
        ptr_r    <= ptr_nxt;
        rdlen_r  <= rdlen_nxt;
        ended_r  <= ended_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_if.valid               = (cnt_r != 2'd0);
  assign out_if.item_kind           = q_r[0].item_kind;
  assign out_if.section             = q_r[0].section;
  assign out_if.id_or_type          = q_r[0].id_or_type;
  assign out_if.flags_or_class      = q_r[0].flags_or_class;
  assign out_if.ttl_or_counts       = q_r[0].ttl_or_counts;
  assign out_if.rdlen_or_count      = q_r[0].rdlen_or_count;
  assign out_if.name_start_or_count = q_r[0].name_start_or_count;
  assign out_if.name_pointer        = q_r[0].name_pointer;
  assign out_if.rdata_start         = q_r[0].rdata_start;
  assign out_if.end_status          = q_r[0].end_status;

  a_rdata_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (phase_r == dnsw_pkg::PH_RDATA) |-> (pc_r != 16'd0))
    else $error("rdata count zero in rdata phase");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last |=> (phase_r == dnsw_pkg::PH_HEADER) && (off_r == 16'd0))
    else $error("no restart after final byte");

  a_hdr_off: assert property (@(posedge clk) disable iff (!rst_n)
    acc && hdr_emit |-> (off_r == 16'd11))
    else $error("header item at wrong offset");

endmodule
